### rtl/mwm_pkg.sv
// Package for the mecanum wheel mixer: fixed-point widths, register codes,
// reset values and the per-stage payload types of the mixer pipeline.
// No dependencies.
`timescale 1ns / 1ps

package mwm_pkg;

    localparam int FRAC_BITS = 14;
    localparam int N_WHEELS  = 4;

    localparam int W_FIELD = 16;
    localparam int W_DUTY  = 8;
    localparam int W_CFG   = 8;

    // A wheel sums three fields, so it needs two more bits.
    localparam int W_WHL = W_FIELD + 2;
    // Magnitudes must hold both the largest wheel and 1.0 plus one.
    localparam int W_MAG = (FRAC_BITS + 2 > W_WHL - 1) ? FRAC_BITS + 2 : W_WHL - 1;
    localparam int W_REM = W_MAG + 1;
    // A normalized magnitude lies in 0..1.0.
    localparam int W_Q    = FRAC_BITS + 1;
    localparam int N_DIV  = FRAC_BITS + 1;
    localparam int W_PROD = W_Q + W_CFG;
    localparam int W_SUM  = W_PROD + 1;

    localparam logic [W_MAG-1:0] ONE_MAG =
        {{(W_MAG - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [W_Q-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic [W_CFG-1:0] BASE_SPEED_RST = 8'd150;
    localparam logic [W_CFG-1:0] MIN_PWM_RST    = 8'd70;

    typedef enum logic [0:0] {
        CFG_BASE_SPEED = 1'b0,
        CFG_MIN_PWM    = 1'b1
    } t_cfg_idx;

    localparam int WHL_FL = 0;
    localparam int WHL_FR = 1;
    localparam int WHL_BL = 2;
    localparam int WHL_BR = 3;

    // Payload of the max stage and of every divider stage.
    typedef struct packed {
        logic [N_WHEELS-1:0][W_REM-1:0] rem;
        logic [N_WHEELS-1:0][W_Q-1:0]   q;
        logic [N_WHEELS-1:0][W_MAG-1:0] mag;
        logic [N_WHEELS-1:0]            neg;
        logic [W_MAG-1:0]               dvs;
        logic                           norm;
    } t_div;

    typedef struct packed {
        logic [N_WHEELS-1:0][W_PROD-1:0] p_base;
        logic [N_WHEELS-1:0][W_PROD-1:0] p_min;
        logic [N_WHEELS-1:0]             zero;
        logic [N_WHEELS-1:0]             neg;
    } t_mul;

endpackage

### rtl/mwm_cmd_if.sv
// Motion command channel of the mecanum wheel mixer: valid/ready and the
// strafe, forward and turn fields. Depends on mwm_pkg.
`timescale 1ns / 1ps

interface mwm_cmd_if import mwm_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic signed [W_FIELD-1:0] strafe;
    logic signed [W_FIELD-1:0] forward;
    logic signed [W_FIELD-1:0] turn;

    modport source (output valid, output strafe, output forward, output turn, input ready);
    modport sink   (input valid, input strafe, input forward, input turn, output ready);

endinterface

### rtl/mwm_duty_if.sv
// Wheel duty channel of the mecanum wheel mixer: valid/ready and the forward
// and reverse duties of the four wheels. Depends on mwm_pkg.
`timescale 1ns / 1ps

interface mwm_duty_if import mwm_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [W_DUTY-1:0] fl_fwd_duty;
    logic [W_DUTY-1:0] fl_rev_duty;
    logic [W_DUTY-1:0] fr_fwd_duty;
    logic [W_DUTY-1:0] fr_rev_duty;
    logic [W_DUTY-1:0] bl_fwd_duty;
    logic [W_DUTY-1:0] bl_rev_duty;
    logic [W_DUTY-1:0] br_fwd_duty;
    logic [W_DUTY-1:0] br_rev_duty;

    modport source (
        output valid,
        output fl_fwd_duty, output fl_rev_duty, output fr_fwd_duty, output fr_rev_duty,
        output bl_fwd_duty, output bl_rev_duty, output br_fwd_duty, output br_rev_duty,
        input  ready
    );
    modport sink (
        input  valid,
        input  fl_fwd_duty, input fl_rev_duty, input fr_fwd_duty, input fr_rev_duty,
        input  bl_fwd_duty, input bl_rev_duty, input br_fwd_duty, input br_rev_duty,
        output ready
    );

endinterface

### rtl/mecanum_wheel_mixer.sv
// Mecanum wheel mixer top level: wheel mixing, normalization by a pipelined
// restoring divider and duty scaling. Depends on mwm_pkg, mwm_cmd_if, mwm_duty_if.
//
//   channel   dir   handshake               payload
//   i_cmd     in    valid/ready             strafe, forward, turn (Q1.14)
//   o_duty    out   valid/ready             fwd/rev duty of FL, FR, BL, BR
//   cfg       in    i_cfg_we (no wait)      i_cfg_idx, i_cfg_data
//
// One item enters per cycle unless a stall at the output has filled every stage;
// the pipeline depth is set by the divider, which forms one quotient bit per stage.
// Reset is synchronous and active low; it clears the valid bits and loads the
// register defaults. A stall at the output only holds the stages behind it
// that are full, so bubbles keep filling and nothing is lost or repeated.
`timescale 1ns / 1ps

module mecanum_wheel_mixer import mwm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  t_cfg_idx          i_cfg_idx,
    input  logic [W_CFG-1:0]  i_cfg_data,
    mwm_cmd_if.sink           i_cmd,
    mwm_duty_if.source        o_duty
);

    localparam int ST_WHL  = 0;
    localparam int ST_MAG  = 1;
    localparam int ST_MAX  = 2;
    localparam int ST_DIV0 = 3;
    localparam int ST_MUL  = ST_DIV0 + N_DIV;
    localparam int ST_OUT  = ST_MUL + 1;
    localparam int N_ST    = ST_OUT + 1;

    logic [W_CFG-1:0] r_base_speed;
    logic [W_CFG-1:0] r_min_pwm;

    logic [N_ST-1:0] r_v;
    logic [N_ST-1:0] en;

    logic signed [N_WHEELS-1:0][W_WHL-1:0] r_whl;
    logic signed [N_WHEELS-1:0][W_WHL-1:0] n_whl;
    logic [N_WHEELS-1:0][W_MAG-1:0]        r_mag;
    logic [N_WHEELS-1:0][W_MAG-1:0]        n_mag;
    logic [N_WHEELS-1:0]                   r_neg;
    logic [N_WHEELS-1:0]                   n_neg;
    // r_ds[0] is the max stage, r_ds[j+1] the divider stage for step j.
    t_div                                  r_ds [N_DIV+1];
    t_div                                  n_max;
    t_div                                  n_ds [1:N_DIV];
    t_mul                                  r_mul;
    t_mul                                  n_mul;
    logic [N_WHEELS-1:0][W_DUTY-1:0]       r_fwd;
    logic [N_WHEELS-1:0][W_DUTY-1:0]       r_rev;
    logic [N_WHEELS-1:0][W_DUTY-1:0]       n_fwd;
    logic [N_WHEELS-1:0][W_DUTY-1:0]       n_rev;

    // One restoring step: the first step compares without a shift, since a
    // magnitude never exceeds the largest one.
    function automatic t_div div_step(input t_div d, input logic shift);
        t_div             res;
        logic [W_REM-1:0] t;
        logic [W_REM-1:0] dvs_ext;
        logic             ge;
        res     = d;
        dvs_ext = {1'b0, d.dvs};
        for (int i = 0; i < N_WHEELS; i++) begin
            t  = shift ? {d.rem[i][W_REM-2:0], 1'b0} : d.rem[i];
            ge = (t >= dvs_ext);
            res.rem[i] = ge ? t - dvs_ext : t;
            res.q[i]   = {d.q[i][W_Q-2:0], ge};
        end
        return res;
    endfunction

    // A stage may load when the output is ready or when it, or any stage after it, holds a bubble.
    for (genvar k = 0; k < N_ST; k++) begin : g_en
        assign en[k] = o_duty.ready || !(&r_v[N_ST-1:k]);
    end

    assign i_cmd.ready = en[ST_WHL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_speed <= BASE_SPEED_RST;
            r_min_pwm    <= MIN_PWM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BASE_SPEED: r_base_speed <= i_cfg_data;
                CFG_MIN_PWM:    r_min_pwm    <= i_cfg_data;
                default:        r_base_speed <= r_base_speed;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_cmd.valid;
            end
            for (int k = 1; k < N_ST; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Wheel mixing.
    always_comb begin
        logic signed [W_WHL-1:0] x;
        logic signed [W_WHL-1:0] y;
        logic signed [W_WHL-1:0] r;
        x = W_WHL'(i_cmd.strafe);
        y = W_WHL'(i_cmd.forward);
        r = W_WHL'(i_cmd.turn);
        n_whl[WHL_FL] = y + x + r;
        n_whl[WHL_FR] = y - x - r;
        n_whl[WHL_BL] = y - x + r;
        n_whl[WHL_BR] = y + x - r;
    end

    always_comb begin
        for (int i = 0; i < N_WHEELS; i++) begin
            n_neg[i] = r_whl[i][W_WHL-1];
            n_mag[i] = W_MAG'($unsigned(n_neg[i] ? -r_whl[i] : r_whl[i]));
        end
    end

    always_comb begin
        logic [W_MAG-1:0] m01;
        logic [W_MAG-1:0] m23;
        logic [W_MAG-1:0] mx;
        m01 = (r_mag[0] > r_mag[1]) ? r_mag[0] : r_mag[1];
        m23 = (r_mag[2] > r_mag[3]) ? r_mag[2] : r_mag[3];
        mx  = (m01 > m23) ? m01 : m23;
        for (int i = 0; i < N_WHEELS; i++) begin
            n_max.rem[i] = W_REM'(r_mag[i]);
            n_max.q[i]   = '0;
        end
        n_max.mag  = r_mag;
        n_max.neg  = r_neg;
        n_max.dvs  = mx;
        n_max.norm = (mx > ONE_MAG);
    end

    for (genvar j = 0; j < N_DIV; j++) begin : g_div
        if (j == 0) begin : g_first
            assign n_ds[j+1] = div_step(r_ds[j], 1'b0);
        end else begin : g_next
            assign n_ds[j+1] = div_step(r_ds[j], 1'b1);
        end
    end

    // Pick the quotient only when the largest wheel is above 1.0.
    always_comb begin
        logic [W_Q-1:0] mm;
        for (int i = 0; i < N_WHEELS; i++) begin
            mm = r_ds[N_DIV].norm ? r_ds[N_DIV].q[i] : W_Q'(r_ds[N_DIV].mag[i]);
            n_mul.p_base[i] = W_PROD'(mm) * W_PROD'(r_base_speed);
            n_mul.p_min[i]  = W_PROD'(ONE_Q - mm) * W_PROD'(r_min_pwm);
            n_mul.zero[i]   = (mm == '0);
        end
        n_mul.neg = r_ds[N_DIV].neg;
    end

    // The blend of two 8-bit values by a weight of at most 1.0 stays in 0..255.
    always_comb begin
        logic [W_SUM-1:0]  sum;
        logic [W_DUTY-1:0] duty;
        for (int i = 0; i < N_WHEELS; i++) begin
            sum  = W_SUM'(r_mul.p_base[i]) + W_SUM'(r_mul.p_min[i]);
            duty = sum[FRAC_BITS +: W_DUTY];
            n_fwd[i] = (!r_mul.zero[i] && !r_mul.neg[i]) ? duty : '0;
            n_rev[i] = (!r_mul.zero[i] &&  r_mul.neg[i]) ? duty : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_WHL]) begin
            r_whl <= n_whl;
        end
        if (en[ST_MAG]) begin
            r_mag <= n_mag;
            r_neg <= n_neg;
        end
        if (en[ST_MAX]) begin
            r_ds[0] <= n_max;
        end
        for (int j = 0; j < N_DIV; j++) begin
            if (en[ST_DIV0 + j]) begin
                r_ds[j+1] <= n_ds[j+1];
            end
        end
        if (en[ST_MUL]) begin
            r_mul <= n_mul;
        end
        if (en[ST_OUT]) begin
            r_fwd <= n_fwd;
            r_rev <= n_rev;
        end
    end

    assign o_duty.valid       = r_v[ST_OUT];
    assign o_duty.fl_fwd_duty = r_fwd[WHL_FL];
    assign o_duty.fl_rev_duty = r_rev[WHL_FL];
    assign o_duty.fr_fwd_duty = r_fwd[WHL_FR];
    assign o_duty.fr_rev_duty = r_rev[WHL_FR];
    assign o_duty.bl_fwd_duty = r_fwd[WHL_BL];
    assign o_duty.bl_rev_duty = r_rev[WHL_BL];
    assign o_duty.br_fwd_duty = r_fwd[WHL_BR];
    assign o_duty.br_rev_duty = r_rev[WHL_BR];

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the mecanum wheel mixer: corner and random motion
// commands, speed register settings, random idling and a long output hold-off.
// Depends on mwm_pkg, mwm_cmd_if, mwm_duty_if and mecanum_wheel_mixer.
`timescale 1ns / 1ps

module tb_top;
    import mwm_pkg::*;

    localparam int PIPE_DEPTH   = FRAC_BITS + 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int DUTY_CEIL    = 255;
    localparam int SPEED_PHASES = 8;
    localparam int CHUNKS       = 10;
    localparam int CHUNK_ITEMS  = 21;

    // Index 0 is fl_fwd_duty, then fl_rev_duty, fr_fwd_duty and so on.
    typedef logic [0:2*N_WHEELS-1][W_DUTY-1:0] t_duties;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    t_cfg_idx         i_cfg_idx;
    logic [W_CFG-1:0] i_cfg_data;

    mwm_cmd_if  cmd_if ();
    mwm_duty_if duty_if ();

    mecanum_wheel_mixer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_if),
        .o_duty     (duty_if)
    );

    bit               in_gaps_on;
    bit               out_stalls_on;
    bit               hold_output;
    logic [W_CFG-1:0] base_speed_now = BASE_SPEED_RST;
    logic [W_CFG-1:0] min_pwm_now    = MIN_PWM_RST;
    t_duties          duty_expect [$];
    t_duties          got_duties;
    t_duties          want_duties;
    int               mismatches      = 0;
    int               cmds_sent       = 0;
    int               results_checked = 0;
    int               settings_used   = 1;
    int               idle_cycles     = 0;

    string field_names [2*N_WHEELS] = '{
        "fl_fwd_duty", "fl_rev_duty", "fr_fwd_duty", "fr_rev_duty",
        "bl_fwd_duty", "bl_rev_duty", "br_fwd_duty", "br_rev_duty"
    };

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Wheel mixing, normalization and duty scaling for one command.
    function automatic t_duties mix_command(input logic signed [W_FIELD-1:0] sx,
                                            input logic signed [W_FIELD-1:0] sy,
                                            input logic signed [W_FIELD-1:0] sr);
        longint  unit;
        longint  peak;
        longint  mm;
        longint  duty;
        longint  wheel [N_WHEELS];
        longint  mag [N_WHEELS];
        t_duties d;
        unit = longint'(1) << FRAC_BITS;
        wheel[WHL_FL] = longint'(sy) + longint'(sx) + longint'(sr);
        wheel[WHL_FR] = longint'(sy) - longint'(sx) - longint'(sr);
        wheel[WHL_BL] = longint'(sy) - longint'(sx) + longint'(sr);
        wheel[WHL_BR] = longint'(sy) + longint'(sx) - longint'(sr);
        peak = 0;
        for (int i = 0; i < N_WHEELS; i++) begin
            mag[i] = (wheel[i] < 0) ? -wheel[i] : wheel[i];
            if (mag[i] > peak)
                peak = mag[i];
        end
        if (peak > unit) begin
            for (int i = 0; i < N_WHEELS; i++)
                mag[i] = (mag[i] << FRAC_BITS) / peak;
        end
        d = '0;
        for (int i = 0; i < N_WHEELS; i++) begin
            // A wheel that truncates to zero after scaling drives neither input.
            if (mag[i] != 0) begin
                mm = (mag[i] > unit) ? unit : mag[i];
                duty = (mm * longint'(base_speed_now) + (unit - mm) * longint'(min_pwm_now))
                       >> FRAC_BITS;
                if (duty > DUTY_CEIL)
                    duty = DUTY_CEIL;
                if (wheel[i] > 0)
                    d[2*i] = W_DUTY'(duty);
                else
                    d[2*i+1] = W_DUTY'(duty);
            end
        end
        return d;
    endfunction

    // Mostly commands inside +-1.0, the rest raw 16-bit values, corners, small values and zero.
    function automatic int draw_field();
        int corners [7] = '{0, 1, -1, 16384, -16384, 32767, -32768};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(0, 32768) - 16384;
            6:                return $urandom_range(0, 65535) - 32768;
            7:                return corners[$urandom_range(0, 6)];
            8:                return $urandom_range(0, 128) - 64;
            default:          return 0;
        endcase
    endfunction

    function automatic logic [W_CFG-1:0] draw_speed();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return W_CFG'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic send_cmd(input int sx, input int sy, input int sr);
        int gap;
        gap = in_gaps_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.strafe  <= W_FIELD'(sx);
        cmd_if.forward <= W_FIELD'(sy);
        cmd_if.turn    <= W_FIELD'(sr);
        do @(posedge i_clk); while (!cmd_if.ready);
        cmds_sent++;
    endtask

    task automatic send_random_cmd();
        send_cmd(draw_field(), draw_field(), draw_field());
    endtask

    // Lets every pending item come out and the pipeline run empty. The first
    // edge lets the checker queue an item accepted at the edge just passed.
    task automatic wait_idle();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (duty_expect.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
    endtask

    task automatic load_speeds(input logic [W_CFG-1:0] base, input logic [W_CFG-1:0] floor_pwm);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_BASE_SPEED;
        i_cfg_data <= base;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MIN_PWM;
        i_cfg_data <= floor_pwm;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        base_speed_now = base;
        min_pwm_now    = floor_pwm;
        settings_used++;
    endtask

    task automatic test_directed_commands();
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
        send_cmd(0, 0, 0);
        send_cmd(16384, 0, 0);
        send_cmd(-16384, 0, 0);
        send_cmd(0, 16384, 0);
        send_cmd(0, -16384, 0);
        send_cmd(0, 0, 16384);
        send_cmd(0, 0, -16384);
        send_cmd(16384, 16384, 16384);
        send_cmd(-16384, -16384, -16384);
        send_cmd(16384, -16384, 16384);
        // Raw values beyond +-1.0 still normalize to full scale.
        send_cmd(32767, 32767, 32767);
        send_cmd(-32768, -32768, -32768);
        send_cmd(-32768, 32767, -32768);
        send_cmd(32767, -32768, 0);
        send_cmd(1, 0, 0);
        send_cmd(-1, 0, 0);
        // Largest wheel exactly 1.0, then just above it.
        send_cmd(8192, 8192, 0);
        send_cmd(8192, 8193, 0);
        // Two wheels of magnitude one vanish once scaled by the large peak.
        send_cmd(16384, 16384, 1);
        // Equal strafe and forward leave two wheels at zero.
        send_cmd(100, 100, 0);
        send_cmd(0, 16384, -1);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        logic [W_CFG-1:0] bases [5] = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd60};
        logic [W_CFG-1:0] floors [5] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd200};
        for (int s = 0; s < 5; s++) begin
            load_speeds(bases[s], floors[s]);
            {in_gaps_on, out_stalls_on} = 2'($urandom_range(0, 3));
            repeat (40) send_random_cmd();
            wait_idle();
        end
    endtask

    task automatic test_backpressure();
        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b0;
        hold_output   = 1'b1;
        repeat (120) send_random_cmd();
        wait_idle();
    endtask

    task automatic test_random_commands();
        for (int phase = 0; phase < SPEED_PHASES; phase++) begin
            load_speeds(draw_speed(), draw_speed());
            for (int c = 0; c < CHUNKS; c++) begin
                {in_gaps_on, out_stalls_on} = 2'($urandom_range(0, 3));
                repeat (CHUNK_ITEMS) send_random_cmd();
            end
            wait_idle();
        end
    endtask

    initial begin : receiver
        int stall;
        duty_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = out_stalls_on ? $urandom_range(0, 19) : 0;
            if (hold_output) begin
                hold_output = 1'b0;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                duty_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            duty_if.ready <= 1'b1;
            do @(posedge i_clk); while (!duty_if.valid);
        end
    end

    // Results are checked before the new command is queued, so a result can
    // never be matched against a command accepted at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (duty_if.valid && duty_if.ready) begin
                got_duties = {duty_if.fl_fwd_duty, duty_if.fl_rev_duty,
                              duty_if.fr_fwd_duty, duty_if.fr_rev_duty,
                              duty_if.bl_fwd_duty, duty_if.bl_rev_duty,
                              duty_if.br_fwd_duty, duty_if.br_rev_duty};
                if (duty_expect.size() == 0) begin
                    report_mismatch("duty item arrived with no command pending");
                end else begin
                    want_duties = duty_expect.pop_front();
                    for (int k = 0; k < 2*N_WHEELS; k++) begin
                        if (got_duties[k] !== want_duties[k])
                            report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                results_checked, field_names[k],
                                got_duties[k], want_duties[k]));
                    end
                    results_checked++;
                end
            end
            if (cmd_if.valid && cmd_if.ready)
                duty_expect.push_back(mix_command(cmd_if.strafe, cmd_if.forward, cmd_if.turn));
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (duty_if.valid && duty_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_BASE_SPEED;
        i_cfg_data     <= '0;
        cmd_if.valid   <= 1'b0;
        cmd_if.strafe  <= '0;
        cmd_if.forward <= '0;
        cmd_if.turn    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_commands();
        test_register_extremes();
        test_backpressure();
        test_random_commands();
        wait_idle();
        $display("summary: %0d commands, %0d duty items checked, %0d speed settings",
                 cmds_sent, results_checked, settings_used);
        $display("summary: corners, raw fields, random idling, long output hold, %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/mwm_pkg.sv
rtl/mwm_cmd_if.sv
rtl/mwm_duty_if.sv
rtl/mecanum_wheel_mixer.sv
tb/sv/tb_top.sv
